[hdl/lir_pkg.sv]
// shared constants and types for the linear interpolation resampler
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // default geometry
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int PHASE_FRAC_BITS_DEF = 14;

  // phase step register
  localparam int              STEP_W     = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd16384;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } lir_qstat_t;

endpackage

`default_nettype wire

[hdl/lir_front.sv]
// front end: takes source samples, keeps sample history, builds queue entries
`timescale 1ns / 1ps
`default_nettype none

module lir_front
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] source_sample,
  input  wire lir_qstat_t                     qstat,
  output      logic                           push,
  output      logic        [SAMPLE_WIDTH-1:0] push_base,
  output      logic        [SAMPLE_WIDTH:0]   push_delta
);

  logic signed [SAMPLE_WIDTH-1:0] curr_sample_reg;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // previous sample becomes the base, delta is new minus previous
  assign push_base  = curr_sample_reg;
  assign push_delta = {source_sample[SAMPLE_WIDTH-1], source_sample}
                    - {curr_sample_reg[SAMPLE_WIDTH-1], curr_sample_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      curr_sample_reg <= '0;
    end else if (push) begin
      curr_sample_reg <= source_sample;
    end
  end

endmodule

`default_nettype wire

[hdl/lir_queue.sv]
// short fifo that decouples the front end from the interpolation engine
`timescale 1ns / 1ps
`default_nettype none

module lir_queue
  import lir_pkg::*;
#(
  parameter int DATA_W = 33
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output      logic [DATA_W-1:0] head_data,
  output      lir_qstat_t        qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == CNT_FULL);
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/lir_back.sv]
// back end: phase accumulator, interpolation multiply and result register
`timescale 1ns / 1ps
`default_nettype none

module lir_back
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lir_qstat_t                     qstat,
  input  wire logic        [SAMPLE_WIDTH-1:0] head_base,
  input  wire logic        [SAMPLE_WIDTH:0]   head_delta,
  output      logic                           pop,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic        [STEP_W-1:0]       cfg_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic signed [SAMPLE_WIDTH-1:0] out_sample,
  output      logic                           last_of_run
);

  localparam int F       = PHASE_FRAC_BITS;
  localparam int PHASE_W = (((F + 1) > STEP_W) ? (F + 1) : STEP_W) + 1;
  localparam int PROD_W  = SAMPLE_WIDTH + F + 2;
  localparam logic [PHASE_W-1:0] PH_ONE   = PHASE_W'(1) << F;
  localparam logic [STEP_W-1:0]  STEP_MIN = STEP_W'(1) << (F - 6);

  logic [PHASE_W-1:0]      phase;
  logic [PHASE_W-1:0]      phase_next;
  logic [STEP_W-1:0]       phase_step;
  logic [PHASE_W-1:0]      phase_sum;
  logic                    phase_big;
  logic                    run_last;
  logic                    have_item;
  logic                    advance;
  logic                    issue;
  logic signed [PROD_W-1:0] prod;

  // stage one: registered product
  logic                    s1_valid;
  logic [SAMPLE_WIDTH-1:0] s1_base;
  logic [SAMPLE_WIDTH-1:0] s1_frac;
  logic                    s1_last;

  assign cfg_ready = 1'b1;

  assign advance   = !out_valid || !out_stall;
  assign have_item = !qstat.empty;
  assign phase_big = (phase >= PH_ONE);
  assign phase_sum = phase + PHASE_W'(phase_step);
  assign run_last  = (phase_sum >= PH_ONE);
  assign issue     = advance && have_item && !phase_big;
  assign pop       = advance && have_item && (phase_big || run_last);

  // base + floor(delta * phase / one), only the low sample bits matter
  assign prod = $signed(head_delta) * $signed({1'b0, phase[F-1:0]});

  always_comb begin
    phase_next = phase;
    if (advance && have_item) begin
      if (phase_big) begin
        phase_next = phase - PH_ONE;
      end else if (run_last) begin
        phase_next = phase_sum - PH_ONE;
      end else begin
        phase_next = phase_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= STEP_RESET;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_valid && cfg_ready) begin
        phase_step <= (cfg_data < STEP_MIN) ? STEP_MIN : cfg_data;
      end
      if (advance) begin
        s1_valid  <= issue;
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_base     <= head_base;
      s1_frac     <= prod[F +: SAMPLE_WIDTH];
      s1_last     <= run_last;
      out_sample  <= s1_base + s1_frac;
      last_of_run <= s1_last;
    end
  end

endmodule

`default_nettype wire

[hdl/linear_interp_resampler_core.sv]
// top level of the linear interpolation sample rate converter
// usage:
//   source samples enter on in_valid / in_stall / source_sample; a transfer
//   happens on a clock edge with in_valid high and in_stall low
//   results leave on out_valid / out_stall / out_sample / last_of_run;
//   last_of_run marks the final result produced for one source sample
//   phase_step (Q2.14 by default) is written on its own valid / ready
//   channel; ready is always high; steps below 1/64 are clamped to 1/64
// path of a sample: queue, stage-one product register, result register
// throughput: unless stalled or out of samples, the back end issues one result
//   per cycle through its single multiplier, up to 64 results per sample;
//   a two-entry queue lets the next samples be taken meanwhile
// reset (rst, synchronous): history and phase cleared, step = 1.0, queue and
//   pipeline emptied
// receiver stall: out_stall freezes the result register and the whole back
//   end; the queue then fills and in_stall rises
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler_core
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // source sample channel
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] source_sample,
  // step register write channel
  input  wire logic                           phase_step_valid,
  output      logic                           phase_step_ready,
  input  wire logic        [STEP_W-1:0]       phase_step,
  // result channel
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic signed [SAMPLE_WIDTH-1:0] out_sample,
  output      logic                           last_of_run
);

  // queue entry: base sample on top, signed delta below
  localparam int ENTRY_W = 2 * SAMPLE_WIDTH + 1;

  lir_qstat_t              qstat;
  logic                    push;
  logic [SAMPLE_WIDTH-1:0] push_base;
  logic [SAMPLE_WIDTH:0]   push_delta;
  logic [ENTRY_W-1:0]      head_data;
  logic                    pop;

  // front: history register and delta
  lir_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .source_sample (source_sample),
    .qstat         (qstat),
    .push          (push),
    .push_base     (push_base),
    .push_delta    (push_delta)
  );

  // decoupling queue
  lir_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_base, push_delta}),
    .pop       (pop),
    .head_data (head_data),
    .qstat     (qstat)
  );

  // back: phase walk, multiply, result register
  lir_back #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head_base   (head_data[ENTRY_W-1 -: SAMPLE_WIDTH]),
    .head_delta  (head_data[SAMPLE_WIDTH:0]),
    .pop         (pop),
    .cfg_valid   (phase_step_valid),
    .cfg_ready   (phase_step_ready),
    .cfg_data    (phase_step),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

[hdl/lir_checker.sv]
// port level checks for the resampler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lir_checker
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_stall,
  input wire logic [SAMPLE_WIDTH-1:0] out_sample,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    last_of_run
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_sample) && $stable(last_of_run))
    else $error("stalled result changed");

  // a run continues back to back until its marked last result
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a run");

  // after reset no result is offered and the queue is not full
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind linear_interp_resampler_core lir_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lir_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_sample  (out_sample),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .last_of_run (last_of_run)
);

`default_nettype wire

[test/linear_interp_resampler_core_test.sv]
// self-checking testbench for the linear interpolation resampler core
`timescale 1ns / 1ps

module linear_interp_resampler_core_test;
  import lir_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int FRAC          = PHASE_FRAC_BITS_DEF;
  localparam int unsigned ONE  = 1 << FRAC;
  // smallest step the block keeps, 1/64
  localparam int unsigned STEP_FLOOR = 1 << (FRAC - 6);
  localparam int MAX_RUN       = 64;
  // cycles to let queued zero-result samples retire before a step write
  localparam int SETTLE_CYCLES = 20;
  // cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT    = 4000;
  localparam int RAND_SEGMENTS = 5;
  localparam int SEG_SAMPLES   = 13;

  // one interpolated output as it should leave the block
  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 last;
  } point_t;

  // directed script rows: either a sample transfer or a step write
  typedef enum logic {ROW_SAMPLE, ROW_STEP} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [15:0]          data;
    logic                 typed;    // expected output written out below
    logic signed [SW-1:0] exp_out;  // single output, last set
  } stim_row_t;

  localparam int DIR_ROWS = 24;

  // at step 1.0 each sample yields exactly one output equal to the previous sample
  localparam stim_row_t SCRIPT [DIR_ROWS] = '{
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h0000},  // history cleared by reset
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, 16'h0001, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'h5555, 1'b1, 16'h0001},
    '{ROW_SAMPLE, 16'hAAAA, 1'b1, 16'h5555},
    '{ROW_STEP,   16'd8192, 1'b0, 16'h0000},  // half step, two outputs per sample
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_STEP,   16'h0000, 1'b0, 16'h0000},  // zero step clamps, full 64-output run
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_STEP,   16'hFFFF, 1'b0, 16'h0000},  // largest step, samples with no output
    '{ROW_SAMPLE, 16'd100,  1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFF9C, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_STEP,   16'd255,  1'b0, 16'h0000},  // just under the floor
    '{ROW_SAMPLE, 16'h4000, 1'b0, 16'h0000},
    '{ROW_STEP,   16'd257,  1'b0, 16'h0000},  // just over the floor
    '{ROW_SAMPLE, 16'hC000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0F0F, 1'b0, 16'h0000}
  };

  // dut ports, the driven inputs known from time zero
  logic              clk              = 1'b0;
  logic              rst              = 1'b1;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [SW-1:0]     source_sample    = '0;
  logic              phase_step_valid = 1'b0;
  logic              phase_step_ready;
  logic [STEP_W-1:0] phase_step       = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [SW-1:0]     out_sample;
  logic              last_of_run;

  // predictor state: sample history, phase accumulator, active step
  logic signed [SW-1:0] hist_prev;
  logic signed [SW-1:0] hist_curr;
  int unsigned          acc_phase;
  int unsigned          cur_step;

  point_t due_points[$];
  int     errors     = 0;
  int     send_idle  = 0;   // percent of cycles the source holds back
  int     recv_idle  = 0;   // percent of cycles the sink stalls
  bit     draining   = 1'b0;
  int     quiet_cycles = 0;

  always #2 clk = ~clk;

  linear_interp_resampler_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .source_sample    (source_sample),
    .phase_step_valid (phase_step_valid),
    .phase_step_ready (phase_step_ready),
    .phase_step       (phase_step),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .last_of_run      (last_of_run)
  );

  // (a*(1-p) + b*p) with a floor shift back to sample scale
  function automatic logic [SW-1:0] interp_point(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b,
                                                 input int unsigned p);
    longint acc;
    acc = longint'(a) * longint'(ONE - p) + longint'(b) * longint'(p);
    acc = acc >>> FRAC;
    return acc[SW-1:0];
  endfunction

  // shift the history, emit while the phase is below one, then drop one
  function automatic void resample_input(input logic [SW-1:0] s, input bit keep);
    int     n;
    point_t pt;
    n = 0;
    hist_prev = hist_curr;
    hist_curr = s;
    while (acc_phase < ONE && n < MAX_RUN) begin
      pt.value = interp_point(hist_prev, hist_curr, acc_phase);
      acc_phase += cur_step;
      n++;
      // last of run when the loop is about to stop
      pt.last = (acc_phase >= ONE) || (n == MAX_RUN);
      if (keep) due_points.push_back(pt);
    end
    acc_phase -= ONE;
  endfunction

  // one sample transfer, with random source gaps before it
  task automatic send_sample(input logic [SW-1:0] s, input bit keep);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    source_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    resample_input(s, keep);
  endtask

  // let every expected output drain and the back end go quiet
  task automatic settle_block();
    draining = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    draining = 1'b0;
  endtask

  // step register write, only with the block idle
  task automatic write_step(input logic [STEP_W-1:0] v);
    settle_block();
    @(negedge clk);
    phase_step_valid <= 1'b1;
    phase_step       <= v;
    @(posedge clk);
    while (!phase_step_ready) @(posedge clk);
    cur_step = (32'(v) < STEP_FLOOR) ? STEP_FLOOR : 32'(v);
    @(negedge clk);
    phase_step_valid <= 1'b0;
  endtask

  // sink: random stalls, none while draining
  always @(negedge clk) begin
    if (draining) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // output check against the oldest expectation
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_points.size() == 0) begin
        $display("%0t: unexpected output, expected none, got %0d last %0b",
                 $time, $signed(out_sample), last_of_run);
        errors++;
      end else begin
        want = due_points.pop_front();
        if (out_sample !== want.value) begin
          $display("%0t: out_sample mismatch, expected %0d, got %0d",
                   $time, want.value, $signed(out_sample));
          errors++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                   $time, want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  // hang detection: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (phase_step_valid && phase_step_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("linear_interp_resampler_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SW-1:0]     s;
    logic [STEP_W-1:0] st;
    point_t            typed_pt;

    hist_prev = '0;
    hist_curr = '0;
    acc_phase = 0;
    cur_step  = 32'(STEP_RESET);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // source sparse gaps, sink stalls about half the time
    send_idle = 9;
    recv_idle = 52;

    // directed script
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_STEP) begin
        write_step(SCRIPT[i].data);
      end else if (SCRIPT[i].typed) begin
        send_sample(SCRIPT[i].data, 1'b0);
        typed_pt.value = SCRIPT[i].exp_out;
        typed_pt.last  = 1'b1;
        due_points.push_back(typed_pt);
      end else begin
        send_sample(SCRIPT[i].data, 1'b1);
      end
    end

    // random part: three idle profiles, each over several step settings
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 9;  recv_idle = 52; end
        1: begin send_idle = 52; recv_idle = 9;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
        case ($urandom_range(0, 3))
          0: st = STEP_W'($urandom_range(0, 300));          // around the floor
          1: st = STEP_W'($urandom_range(0, 65535));        // anywhere
          2: st = STEP_W'($urandom_range(8192, 32768));     // typical ratios
          default: st = STEP_W'($urandom_range(50000, 65535));  // heavy decimation
        endcase
        write_step(st);
        repeat (SEG_SAMPLES) begin
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
              0: s = 16'h7FFF;
              1: s = 16'h8000;
              2: s = 16'hFFFF;
              default: s = 16'h0000;
            endcase
          end else begin
            s = SW'($urandom_range(0, 65535));
          end
          send_sample(s, 1'b1);
        end
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("linear_interp_resampler_core_test: done, clean");
    end else begin
      $display("linear_interp_resampler_core_test: done, errors");
    end
    $finish;
  end

endmodule
